[rtl/core/mfc_pkg.sv]
// shared types and constants of the multi-filter same-padded correlator
`timescale 1ns / 1ps

package mfc_pkg;

	// fixed field widths
	localparam int VAL_W   = 16;
	localparam int PROD_W  = 2 * VAL_W;
	localparam int SUM_W   = 36;
	localparam int POS_W   = 10;
	localparam int FCFG_W  = 3;
	localparam int TCFG_W  = 4;
	localparam int FIDX_W  = 2;
	localparam int TIDX_W  = 4;
	localparam int CFG_W   = 4;
	localparam int GRP_N   = 3;
	localparam int GRP_W   = PROD_W + 2;

	// job queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// item kind
	typedef enum logic {
		KIND_COEF   = 1'b0,
		KIND_SAMPLE = 1'b1
	} kind_t;

	// configuration register indexes
	typedef enum logic {
		REG_FILTER_COUNT = 1'b0,
		REG_TAP_COUNT    = 1'b1
	} cfg_reg_t;

	// one queued job: a tap write or a run of output positions
	typedef struct packed {
		kind_t              kind;
		logic [FIDX_W-1:0]  fidx;
		logic [TIDX_W-1:0]  tidx;
		logic [VAL_W-1:0]   value;
		logic [FCFG_W-1:0]  f_last;
		logic [TCFG_W-1:0]  t_eff;
		logic [TCFG_W-1:0]  base0;
		logic [TCFG_W-1:0]  pos_last;
		logic [POS_W-1:0]   p0;
		logic [TCFG_W-1:0]  n_sat;
		logic               overrun;
	} job_t;

	// result tag carried along the arithmetic pipeline
	typedef struct packed {
		logic [FIDX_W-1:0]  filt;
		logic [POS_W-1:0]   pos;
		logic               overrun;
		logic               run_end;
	} res_meta_t;

endpackage

[rtl/core/mfc_queue.sv]
// short job queue that decouples the classifying front from the compute back
`timescale 1ns / 1ps

module mfc_queue import mfc_pkg::*; #(
	parameter int TAPS = 9
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  job_t                         push_job,
	input  logic [TAPS-1:0][VAL_W-1:0]   push_win,
	output logic                         full,
	input  logic                         pop,
	output logic                         empty,
	output job_t                         head_job,
	output logic [TAPS-1:0][VAL_W-1:0]   head_win
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t                        job_q [QUEUE_DEPTH];
	logic [TAPS-1:0][VAL_W-1:0]  win_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]            wr_ptr_q;
	logic [PTR_W-1:0]            rd_ptr_q;
	logic [CNT_W-1:0]            count_q;

	// occupancy flags
	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign head_job = job_q[rd_ptr_q];
	assign head_win = win_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			job_q[wr_ptr_q] <= push_job;
			win_q[wr_ptr_q] <= push_win;
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("job pushed into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("job popped from an empty queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH)) else $error("queue fill level out of range");

endmodule

[rtl/core/mfc_front.sv]
// front end: configuration, sample window, position bookkeeping and job classification
`timescale 1ns / 1ps

module mfc_front import mfc_pkg::*; #(
	parameter int MAX_FILTERS = 4,
	parameter int MAX_TAPS    = 9,
	parameter int MAX_LENGTH  = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic                             cfg_index,
	input  logic [CFG_W-1:0]                 cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             kind,
	input  logic [FIDX_W-1:0]                filter_index,
	input  logic [TIDX_W-1:0]                tap_index,
	input  logic signed [VAL_W-1:0]          value,
	input  logic                             last,
	output logic                             q_push,
	output job_t                             q_job,
	output logic [MAX_TAPS-1:0][VAL_W-1:0]   q_win,
	input  logic                             q_full
);

	localparam int CNT_W = $clog2(MAX_LENGTH);
	localparam logic [CNT_W-1:0] LEN_LAST = CNT_W'(MAX_LENGTH - 1);

	logic [FCFG_W-1:0]               fcnt_q;
	logic [TCFG_W-1:0]               tcnt_q;
	logic [MAX_TAPS-1:0][VAL_W-1:0]  win_q;
	logic [CNT_W-1:0]                count_q;
	logic                            full_idx_q;
	logic                            overrun_q;

	logic                            accept;
	logic                            is_sample;
	logic                            slot_ok;
	logic [TCFG_W-1:0]               t_eff;
	logic [FCFG_W-1:0]               f_eff;
	logic [TCFG_W-1:0]               behind;
	logic [TCFG_W-1:0]               ahead;
	logic                            n_ge;
	logic                            at_end;
	logic [TCFG_W-1:0]               pos_last;
	logic [MAX_TAPS-1:0][VAL_W-1:0]  win_next;

	assign in_ready  = !q_full;
	assign accept    = in_valid && in_ready;
	assign is_sample = (kind == KIND_SAMPLE);
	assign slot_ok   = (int'(filter_index) < MAX_FILTERS) && (int'(tap_index) < MAX_TAPS);

	// clamp the configured counts into their legal ranges
	always_comb begin
		if (tcnt_q == '0) begin
			t_eff = TCFG_W'(1);
		end else if (int'(tcnt_q) > MAX_TAPS) begin
			t_eff = TCFG_W'(MAX_TAPS);
		end else begin
			t_eff = tcnt_q;
		end
		if (fcnt_q == '0) begin
			f_eff = FCFG_W'(1);
		end else if (int'(fcnt_q) > MAX_FILTERS) begin
			f_eff = FCFG_W'(MAX_FILTERS);
		end else begin
			f_eff = fcnt_q;
		end
	end

	assign behind = (t_eff - 1'b1) >> 1;
	assign ahead  = t_eff - 1'b1 - behind;
	assign n_ge   = int'(count_q) >= int'(ahead);
	assign at_end = (count_q == LEN_LAST);

	// window after the new sample shifts in
	always_comb begin
		win_next[0] = value;
		for (int i = 1; i < MAX_TAPS; i++) begin
			win_next[i] = win_q[i-1];
		end
	end

	// positions emitted by this sample: one normally, the whole tail on the last
	always_comb begin
		if (!last) begin
			pos_last = '0;
		end else if (n_ge) begin
			pos_last = ahead;
		end else begin
			pos_last = TCFG_W'(count_q);
		end
	end

	// job build
	always_comb begin
		q_job.kind     = is_sample ? KIND_SAMPLE : KIND_COEF;
		q_job.fidx     = filter_index;
		q_job.tidx     = tap_index;
		q_job.value    = value;
		q_job.f_last   = f_eff - 1'b1;
		q_job.t_eff    = t_eff;
		q_job.base0    = (last ? pos_last : ahead) + behind;
		q_job.pos_last = pos_last;
		q_job.p0       = n_ge ? POS_W'(count_q - CNT_W'(ahead)) : '0;
		q_job.n_sat    = (int'(count_q) > 15) ? TCFG_W'(15) : TCFG_W'(count_q);
		q_job.overrun  = overrun_q || full_idx_q;
		q_win          = win_next;
		q_push         = accept && (is_sample ? (last || n_ge) : slot_ok);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcnt_q <= FCFG_W'(4);
			tcnt_q <= TCFG_W'(3);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FILTER_COUNT: begin
					fcnt_q <= cfg_data[FCFG_W-1:0];
				end
				REG_TAP_COUNT: begin
					tcnt_q <= cfg_data[TCFG_W-1:0];
				end
			endcase
		end
	end

	// window and vector length tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q      <= '0;
			count_q    <= '0;
			full_idx_q <= 1'b0;
			overrun_q  <= 1'b0;
		end else if (accept && is_sample) begin
			if (last) begin
				win_q      <= '0;
				count_q    <= '0;
				full_idx_q <= 1'b0;
				overrun_q  <= 1'b0;
			end else begin
				win_q <= win_next;
				if (at_end) begin
					if (full_idx_q) begin
						overrun_q <= 1'b1;
					end else begin
						full_idx_q <= 1'b1;
					end
				end else begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

endmodule

[rtl/core/mfc_back.sv]
// back end: tap table, per-result issue and the multiply-sum pipeline
`timescale 1ns / 1ps

module mfc_back import mfc_pkg::*; #(
	parameter int MAX_FILTERS = 4,
	parameter int MAX_TAPS    = 9
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             head_valid,
	input  job_t                             head_job,
	input  logic [MAX_TAPS-1:0][VAL_W-1:0]   head_win,
	output logic                             pop,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [FIDX_W-1:0]                out_filter,
	output logic [POS_W-1:0]                 position,
	output logic signed [SUM_W-1:0]          sum,
	output logic                             overrun,
	output logic                             run_end
);

	localparam int FI_W  = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
	localparam int TI_W  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int NGRP  = (MAX_TAPS + GRP_N - 1) / GRP_N;

	// tap table, one row per filter
	logic [MAX_TAPS-1:0][VAL_W-1:0]  tap_mem [MAX_FILTERS];

	logic [TCFG_W-1:0]               pos_q;
	logic [FCFG_W-1:0]               filt_q;

	logic                            adv;
	logic                            is_smp;
	logic                            last_res;
	logic                            issue;
	logic                            coef_wr;
	logic [TCFG_W-1:0]               base;
	logic [MAX_TAPS-1:0][VAL_W-1:0]  samp_d;
	res_meta_t                       meta_d;

	logic                            v_s1;
	logic [MAX_TAPS-1:0][VAL_W-1:0]  samp_s1;
	logic [MAX_TAPS-1:0][VAL_W-1:0]  taps_s1;
	res_meta_t                       meta_s1;
	logic                            v_s2;
	logic signed [PROD_W-1:0]        prod_s2 [MAX_TAPS];
	res_meta_t                       meta_s2;
	logic                            v_s3;
	logic signed [GRP_W-1:0]         grp_d [NGRP];
	logic signed [GRP_W-1:0]         grp_s3 [NGRP];
	res_meta_t                       meta_s3;
	logic signed [SUM_W-1:0]         sum_d;
	logic                            out_valid_q;
	logic signed [SUM_W-1:0]         sum_q;
	res_meta_t                       meta_q;

	// the whole pipeline moves when the output register can take a result
	assign adv      = !out_valid_q || out_ready;
	assign is_smp   = head_valid && (head_job.kind == KIND_SAMPLE);
	assign last_res = (pos_q == head_job.pos_last) && (filt_q == head_job.f_last);
	assign issue    = adv && is_smp;
	assign coef_wr  = adv && head_valid && (head_job.kind == KIND_COEF);
	assign pop      = coef_wr || (issue && last_res);
	assign base     = head_job.base0 - pos_q;

	// pick the window sample under each tap, zero outside the vector
	always_comb begin
		logic [TCFG_W-1:0] d;
		logic              ok;
		for (int t = 0; t < MAX_TAPS; t++) begin
			d  = base - TCFG_W'(t);
			ok = (TCFG_W'(t) <= base) && (TCFG_W'(t) < head_job.t_eff) &&
				(d <= head_job.n_sat);
			samp_d[t] = ok ? head_win[TI_W'(d)] : '0;
		end
		meta_d.filt    = FIDX_W'(filt_q);
		meta_d.pos     = head_job.p0 + POS_W'(pos_q);
		meta_d.overrun = head_job.overrun;
		meta_d.run_end = last_res;
	end

	// filter and position counters walking the current job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			filt_q <= '0;
		end else if (issue) begin
			if (last_res) begin
				pos_q  <= '0;
				filt_q <= '0;
			end else if (filt_q == head_job.f_last) begin
				filt_q <= '0;
				pos_q  <= pos_q + 1'b1;
			end else begin
				filt_q <= filt_q + 1'b1;
			end
		end
	end

	// tap table write and registered row read
	always_ff @(posedge clk) begin
		if (coef_wr) begin
			tap_mem[FI_W'(head_job.fidx)][TI_W'(head_job.tidx)] <= head_job.value;
		end
		if (adv) begin
			taps_s1 <= tap_mem[FI_W'(filt_q)];
		end
	end

	// group partial sums
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_d[g] = '0;
		end
		for (int t = 0; t < MAX_TAPS; t++) begin
			grp_d[t / GRP_N] = grp_d[t / GRP_N] + GRP_W'(prod_s2[t]);
		end
	end

	// final sum; at most 31 Q2.30 products fit the sum field
	always_comb begin
		sum_d = '0;
		for (int g = 0; g < NGRP; g++) begin
			sum_d = sum_d + SUM_W'(grp_s3[g]);
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= issue;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (adv) begin
			samp_s1 <= samp_d;
			meta_s1 <= meta_d;
			for (int t = 0; t < MAX_TAPS; t++) begin
				prod_s2[t] <= $signed(samp_s1[t]) * $signed(taps_s1[t]);
			end
			meta_s2 <= meta_s1;
			grp_s3  <= grp_d;
			meta_s3 <= meta_s2;
			sum_q   <= sum_d;
			meta_q  <= meta_s3;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_filter = meta_q.filt;
	assign position   = meta_q.pos;
	assign sum        = sum_q;
	assign overrun    = meta_q.overrun;
	assign run_end    = meta_q.run_end;

	a_counter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		is_smp |-> (pos_q <= head_job.pos_last) && (filt_q <= head_job.f_last))
		else $error("issue counters ran past the current job");

	a_job_held: assert property (@(posedge clk) disable iff (!arst_n)
		issue && !last_res |=> head_valid && (head_job.kind == KIND_SAMPLE))
		else $error("sample job left the queue head before its last result");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && out_valid_q && !out_ready |=> v_s3 && out_valid_q)
		else $error("pipeline moved while the output was stalled");

endmodule

[rtl/core/multi_filter_conv1d_same_pad.sv]
// top level of the multi-filter same-padded 1-D correlator
`timescale 1ns / 1ps

// Usage:
// Input channel (in_valid/in_ready) carries coefficient transactions (kind 0),
// which load one tap of one filter, and sample transactions (kind 1) of an
// input vector, the final one marked by last. Output channel
// (out_valid/out_ready) gives one Q6.30 sum per filter and output position,
// positions ascending, filters ascending within a position; run_end marks
// the last result of each sample transaction.
// Configuration: cfg_we writes cfg_data into filter_count (index 0) or
// tap_count (index 1); write only while no results are pending.
// Throughput: the front takes one transaction per cycle while its four-entry
// job queue has room. The back issues one result per cycle, while the output
// is not stalled, into a four-stage multiply and sum pipeline; a sample gives
// up to filter_count results, a last sample (ahead + 1) * filter_count at most,
// and a coefficient only a tap table write.
// Reset: window, sample count and overrun clear, filter_count is 4 and
// tap_count 3; the tap table holds nothing until loaded.
// A stalled receiver freezes the back pipeline; the queue then fills and
// in_ready drops.

module multi_filter_conv1d_same_pad import mfc_pkg::*; #(
	parameter int MAX_FILTERS = 4,
	parameter int MAX_TAPS    = 9,
	parameter int MAX_LENGTH  = 1024
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     kind,
	input  logic [FIDX_W-1:0]        filter_index,
	input  logic [TIDX_W-1:0]        tap_index,
	input  logic signed [VAL_W-1:0]  value,
	input  logic                     last,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [FIDX_W-1:0]        out_filter,
	output logic [POS_W-1:0]         position,
	output logic signed [SUM_W-1:0]  sum,
	output logic                     overrun,
	output logic                     run_end
);

	logic                            q_push;
	job_t                            q_job;
	logic [MAX_TAPS-1:0][VAL_W-1:0]  q_win;
	logic                            q_full;
	logic                            q_pop;
	logic                            q_empty;
	job_t                            head_job;
	logic [MAX_TAPS-1:0][VAL_W-1:0]  head_win;

	// front: classify transactions and track the window
	mfc_front #(
		.MAX_FILTERS (MAX_FILTERS),
		.MAX_TAPS    (MAX_TAPS),
		.MAX_LENGTH  (MAX_LENGTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.filter_index (filter_index),
		.tap_index    (tap_index),
		.value        (value),
		.last         (last),
		.q_push       (q_push),
		.q_job        (q_job),
		.q_win        (q_win),
		.q_full       (q_full)
	);

	// job queue
	mfc_queue #(
		.TAPS (MAX_TAPS)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (q_job),
		.push_win (q_win),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head_job (head_job),
		.head_win (head_win)
	);

	// back: tap table and arithmetic
	mfc_back #(
		.MAX_FILTERS (MAX_FILTERS),
		.MAX_TAPS    (MAX_TAPS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (!q_empty),
		.head_job   (head_job),
		.head_win   (head_win),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_filter (out_filter),
		.position   (position),
		.sum        (sum),
		.overrun    (overrun),
		.run_end    (run_end)
	);

endmodule
